// ----- sv/i2a_pkg.sv -----
package i2a_pkg;

	localparam int VALUE_W        = 64;
	localparam int VALUE_BITS_DEF = 64;
	localparam int CHAR_W         = 7;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               hex_mode;
		logic               signed_mode;
	} num_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} txt_t;

	// per-cycle command shared by every cell of the digit row
	typedef struct packed {
		logic clr;
		logic bit_shift;
		logic dig_shift;
		logic dec;
	} i2a_ctrl_t;

	// decimal digits of 2^bits - 1 (1233/4096 ~ log10(2), exact up to 64 bits)
	function automatic int dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {3'b000, d};
		return (d < 4'd10) ? (CH_ZERO + dw) : (CH_A + dw - 7'd10);
	endfunction

endpackage

// ----- sv/i2a_cell.sv -----
module i2a_cell (
	input  logic                clk,
	input  i2a_pkg::i2a_ctrl_t  ctrl,
	input  logic                bit_in,
	input  logic [3:0]          digit_in,
	output logic                bit_out,
	output logic [3:0]          digit_out
);
	import i2a_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] corr;

	// shift-and-add-3 correction only in base ten; in base sixteen the cell is a plain nibble
	always_comb begin
		corr = (ctrl.dec && (digit_q >= 4'd5)) ? (digit_q + 4'd3) : digit_q;
	end

	assign bit_out   = corr[3];
	assign digit_out = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= 4'd0;
		end else if (ctrl.bit_shift) begin
			digit_q <= {corr[2:0], bit_in};
		end else if (ctrl.dig_shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ----- sv/i2a_chain.sv -----
module i2a_chain #(
	parameter int NDIG = 20
) (
	input  logic               clk,
	input  i2a_pkg::i2a_ctrl_t ctrl,
	input  logic               bit_in,
	output logic [3:0]         top_digit
);
	import i2a_pkg::*;

	logic [NDIG:0]      bit_c;
	logic [3:0]         dig_c [NDIG+1];

	assign bit_c[0] = bit_in;
	assign dig_c[0] = 4'd0;

	// bits ripple upwards during conversion, digits move up one cell per dropped zero or output digit
	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		i2a_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.bit_in    (bit_c[i]),
			.digit_in  (dig_c[i]),
			.bit_out   (bit_c[i+1]),
			.digit_out (dig_c[i+1])
		);
	end

	assign top_digit = dig_c[NDIG];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) ctrl.bit_shift |-> !bit_c[NDIG])
		else $error("digit row overflowed during conversion");
`endif

endmodule

// ----- sv/integer_to_ascii_digits_unit.sv -----
// Integer to ASCII text converter.
// Input channel num (num_valid/num_ready): one 64-bit value with hex_mode and
// signed_mode flags; only the low VALUE_BITS bits are used.
// Output channel txt (txt_valid/txt_ready): one ASCII character per transaction,
// most significant digit first, lower-case hex, a leading '-' for negative
// signed values, last set on the final character. Zero gives a single '0'.
// Steps per value: take it, shift its VALUE_BITS bits one at a time through the
// row of digit cells (shift-and-add-3 in base ten), drop leading zero digits (up
// to dec_digits(VALUE_BITS)-1), then emit one character at a time. Dropped zeros
// and digits always add up to dec_digits(VALUE_BITS).
// A new value is taken once the last character sits in the output register,
// so the next conversion overlaps with the receiver taking that character.
// When txt_ready is low the current character holds and emission pauses.
// Reset clears the controller and the output valid; no clearing pass is needed.
module integer_to_ascii_digits_unit #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          num_valid,
	output logic          num_ready,
	input  i2a_pkg::num_t num,
	output logic          txt_valid,
	input  logic          txt_ready,
	output i2a_pkg::txt_t txt
);
	import i2a_pkg::*;

	localparam int NDIG = dec_digits(VALUE_BITS);
	localparam int BCW  = $clog2(VALUE_BITS);
	localparam int RCW  = $clog2(NDIG + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q, state_d;
	logic [VALUE_BITS-1:0]  mag_q;
	logic [BCW-1:0]         bcnt_q;
	logic [RCW-1:0]         rem_q;
	logic                   neg_q;
	logic                   dec_q;
	txt_t                   txt_q, txt_d;
	logic                   txt_valid_q;

	logic [VALUE_BITS-1:0]  raw;
	logic [VALUE_BITS-1:0]  mag_in;
	logic                   is_neg;
	logic                   accept;
	logic                   out_free;
	logic                   load;
	i2a_ctrl_t              ctrl;
	logic [3:0]             top_digit;

	assign raw      = num.value[VALUE_BITS-1:0];
	assign is_neg   = num.signed_mode & raw[VALUE_BITS-1];
	assign mag_in   = is_neg ? (~raw + VALUE_BITS'(1)) : raw;
	assign num_ready = (state_q == ST_IDLE);
	assign accept   = num_valid && num_ready;
	assign out_free = !txt_valid_q || txt_ready;

	always_comb begin
		state_d        = state_q;
		ctrl.clr       = 1'b0;
		ctrl.bit_shift = 1'b0;
		ctrl.dig_shift = 1'b0;
		ctrl.dec       = dec_q;
		load           = 1'b0;
		txt_d          = txt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.clr = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.bit_shift = 1'b1;
				if (bcnt_q == BCW'(VALUE_BITS - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, always keeping the units digit
				if ((top_digit == 4'd0) && (rem_q > RCW'(1))) begin
					ctrl.dig_shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (neg_q) begin
						txt_d.character = CH_MINUS;
						txt_d.last      = 1'b0;
					end else begin
						txt_d.character = digit_char(top_digit);
						txt_d.last      = (rem_q == RCW'(1));
						ctrl.dig_shift  = 1'b1;
						if (rem_q == RCW'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			txt_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			dec_q       <= 1'b0;
			bcnt_q      <= '0;
			rem_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				txt_valid_q <= 1'b1;
			end else if (txt_ready) begin
				txt_valid_q <= 1'b0;
			end
			if (accept) begin
				neg_q  <= is_neg;
				dec_q  <= !num.hex_mode;
				bcnt_q <= '0;
				rem_q  <= RCW'(NDIG);
			end else begin
				if (ctrl.bit_shift) begin
					bcnt_q <= bcnt_q + BCW'(1);
				end
				if (ctrl.dig_shift) begin
					rem_q <= rem_q - RCW'(1);
				end
				if (load && neg_q) begin
					neg_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
		end else if (ctrl.bit_shift) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
		if (load) begin
			txt_q <= txt_d;
		end
	end

	i2a_chain #(
		.NDIG (NDIG)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.bit_in    (mag_q[VALUE_BITS-1]),
		.top_digit (top_digit)
	);

	assign txt_valid = txt_valid_q;
	assign txt       = txt_q;

`ifndef SYNTHESIS
	a_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(txt_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("character loaded outside emission");
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("no digits left while emitting");
	a_sign_done: assert property (@(posedge clk) disable iff (!arst_n)
		num_ready |-> !neg_q)
		else $error("minus sign pending while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && txt_d.last) |=> (state_q == ST_IDLE))
		else $error("final character did not end the transaction sequence");
`endif

endmodule

// ----- bench/tb_integer_to_ascii_digits_unit.sv -----
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits_unit;
	import i2a_pkg::*;

	localparam int          DATA_BITS    = VALUE_BITS_DEF;
	localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - DATA_BITS);
	localparam logic [63:0] MOST_NEG     = 64'd1 << (DATA_BITS - 1);
	localparam int          DEC_BASE     = 10;
	localparam int          HEX_BASE     = 16;
	localparam int          TAIL_CYCLES  = 250;
	localparam int          QUIET_LIMIT  = 5000;
	localparam int          PHASE_ITEMS  = 25;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  num_valid  = 1'b0;
	logic  num_ready;
	num_t  num        = '0;
	logic  txt_valid;
	logic  txt_ready  = 1'b0;
	txt_t  txt;

	txt_t        expected_chars[$];
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	int          idle_pct     = 0;
	int          stall_pct    = 0;

	integer_to_ascii_digits_unit #(
		.VALUE_BITS(DATA_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num(num),
		.txt_valid(txt_valid),
		.txt_ready(txt_ready),
		.txt(txt)
	);

	always #6 clk = ~clk;

	// works out the characters one number should produce
	function automatic void predict_text(input num_t n);
		logic [63:0] mag;
		logic [63:0] base;
		logic [3:0]  digit_q[$];
		logic [6:0]  d7;
		txt_t        ch;
		mag  = n.value & VALUE_MASK;
		base = n.hex_mode ? 64'(HEX_BASE) : 64'(DEC_BASE);
		if (n.signed_mode && mag[DATA_BITS-1]) begin
			ch.character = CH_MINUS;
			ch.last      = 1'b0;
			expected_chars.push_back(ch);
			mag = (~mag + 64'd1) & VALUE_MASK;
		end
		do begin
			digit_q.push_front(4'(mag % base));
			mag = mag / base;
		end while (mag != 0);
		foreach (digit_q[k]) begin
			d7 = {3'b000, digit_q[k]};
			ch.character = (digit_q[k] < 4'(DEC_BASE)) ? CH_ZERO + d7
				: CH_A + d7 - 7'(DEC_BASE);
			ch.last      = (k == digit_q.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	function automatic num_t make_number(input logic [63:0] v, input logic hx, input logic sg);
		num_t n;
		n.value       = v;
		n.hex_mode    = hx;
		n.signed_mode = sg;
		return n;
	endfunction

	function automatic logic [63:0] power_of_ten(input int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'(DEC_BASE);
		return p;
	endfunction

	function automatic num_t random_number();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(3, 0))
			0: ;
			1: v = v >> $urandom_range(63, 0);
			2: v = ~(v >> $urandom_range(63, 1)) + 64'd1;
			default: v = power_of_ten($urandom_range(19, 0)) - 64'($urandom_range(1, 0));
		endcase
		return make_number(v, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
	endfunction

	task automatic send_number(input num_t n);
		while ($urandom_range(99, 0) < idle_pct) begin
			num_valid <= 1'b0;
			@(posedge clk);
		end
		num_valid <= 1'b1;
		num       <= n;
		@(posedge clk);
		while (!num_ready) @(posedge clk);
		predict_text(n);
	endtask

	task automatic wait_for_text_drained();
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_zero();
		send_number(make_number(64'd0, 1'b0, 1'b0));
		send_number(make_number(64'd0, 1'b1, 1'b0));
		send_number(make_number(64'd0, 1'b0, 1'b1));
		send_number(make_number(64'd0, 1'b1, 1'b1));
	endtask

	task automatic test_unsigned_extremes();
		send_number(make_number(VALUE_MASK, 1'b0, 1'b0));
		send_number(make_number(VALUE_MASK, 1'b1, 1'b0));
		send_number(make_number(64'd1, 1'b0, 1'b0));
		send_number(make_number(64'd9, 1'b0, 1'b0));
		send_number(make_number(64'd10, 1'b0, 1'b0));
		send_number(make_number(64'd15, 1'b1, 1'b0));
		send_number(make_number(64'd16, 1'b1, 1'b0));
		send_number(make_number(power_of_ten(19), 1'b0, 1'b0));
		send_number(make_number(MOST_NEG, 1'b0, 1'b0));
	endtask

	// minus one, the wrapping most negative value, the largest positive one and minus ten
	task automatic test_signed_values();
		send_number(make_number(VALUE_MASK, 1'b0, 1'b1));
		send_number(make_number(VALUE_MASK, 1'b1, 1'b1));
		send_number(make_number(MOST_NEG, 1'b0, 1'b1));
		send_number(make_number(MOST_NEG, 1'b1, 1'b1));
		send_number(make_number(MOST_NEG - 64'd1, 1'b0, 1'b1));
		send_number(make_number(~64'd10 + 64'd1, 1'b1, 1'b1));
	endtask

	// sender holds off until the output side has caught up completely
	task automatic test_drain_pause();
		repeat (3) send_number(random_number());
		num_valid <= 1'b0;
		wait_for_text_drained();
		repeat (3) send_number(random_number());
	endtask

	task automatic test_random_numbers(input int idle, input int stall, input int count);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (count) send_number(random_number());
	endtask

	always @(posedge clk) begin
		txt_ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && txt_valid && txt_ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character transaction %h", txt.character);
				mismatches++;
			end else begin
				if (txt.character !== expected_chars[0].character) begin
					$error("character: expected %h, got %h",
						expected_chars[0].character, txt.character);
					mismatches++;
				end
				if (txt.last !== expected_chars[0].last) begin
					$error("last: expected %b, got %b", expected_chars[0].last, txt.last);
					mismatches++;
				end
				void'(expected_chars.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((num_valid && num_ready) || (txt_valid && txt_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("integer_to_ascii_digits_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero();
		test_unsigned_extremes();
		test_signed_values();
		test_drain_pause();
		test_random_numbers(0, 0, PHASE_ITEMS);
		test_random_numbers(81, 0, PHASE_ITEMS);
		test_random_numbers(0, 81, PHASE_ITEMS);
		test_random_numbers(18, 18, PHASE_ITEMS);
		num_valid <= 1'b0;

		wait_for_text_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("integer_to_ascii_digits_unit regression: pass");
		else
			$display("integer_to_ascii_digits_unit regression: fail");
		$finish;
	end

endmodule
